### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the deadband logger.
// Each macro samples on the rising edge of clk_i; the modules that use them
// must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while the reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check that also holds while the reset is applied.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/ddtl_pkg.sv
// Shared constants and types of the deadband delta-time logger.
// Used by ddtl_div and deadband_delta_time_logger; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ddtl_pkg;

  // Ring buffer depth and the widths that follow from it.
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  // Field widths.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned THR_W   = 31;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ENTRY_W = DELTA_W + DATA_W;

  // Divider widths: the dividend is 2*elapsed + interval.
  localparam int unsigned NUM_W  = TIME_W + 2;
  localparam int unsigned DEN_W  = IVL_W + 1;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  // Configuration port.
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL  = 1'b1;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

### rtl/ddtl_div.sv
// Radix-2 restoring divider that quantizes elapsed time to whole intervals,
// rounded half up and saturated to the delta width. Depends on ddtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddtl_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ddtl_pkg::TIME_W-1:0]  elapsed_i,
  input  wire logic [ddtl_pkg::IVL_W-1:0]   interval_i,
  output logic      [ddtl_pkg::DELTA_W-1:0] quotient_o,
  output ddtl_pkg::div_status_t             status_o
);
  import ddtl_pkg::*;

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [IVL_W-1:0]  ivl;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    rem_sub;
  logic              fits;

  // An interval of zero counts as one second.
  assign ivl       = (interval_i == '0) ? IVL_W'(1) : interval_i;
  assign rem_shift = {rem_q, num_q[NUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign fits      = (rem_shift >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(NUM_W);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The dividend register collects the quotient bits as it shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NUM_W'({elapsed_i, 1'b0}) + NUM_W'(ivl);
      den_q <= {ivl, 1'b0};
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
  end

  assign quotient_o    = (|num_q[NUM_W-1:DELTA_W]) ? '1 : num_q[DELTA_W-1:0];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

`default_nettype wire

### rtl/deadband_delta_time_logger.sv
// Deadband change logger with a ring-buffer store of readings and time deltas.
// Depends on ddtl_pkg, ddtl_div and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// One item at a time: in_ready_o is high only while the sequencer is idle.
// The first item after reset goes straight to the done state and is stored, an
// item that falls inside the deadband passes the difference and compare states
// and is dropped, and any other item also waits in S_DIV for the divider, which
// produces one quotient bit per cycle. The result is held in an output register,
// so the next item is taken while a result still waits for out_ready_i. The store
// needs no clearing pass after reset: only entries that were written are ever used.
module deadband_delta_time_logger (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ddtl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ddtl_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ddtl_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [ddtl_pkg::DATA_W-1:0] reading_i,
  input  wire logic [ddtl_pkg::TIME_W-1:0]   now_seconds_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               stored_o,
  output logic      [ddtl_pkg::DELTA_W-1:0]  interval_delta_o,
  output logic      [ddtl_pkg::COUNT_W-1:0]  entry_count_o
);
  import ddtl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIFF = 5'b00010,
    S_CMP  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [THR_W-1:0] thr_q;
  logic [IVL_W-1:0] interval_q;
  logic             cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;

  // Store and bookkeeping
  logic [ENTRY_W-1:0] record_store_q [DEPTH];
  logic [DATA_W-1:0]  rdata_q;
  logic [ADDR_W-1:0]  slot_q;
  logic [ADDR_W-1:0]  newest_addr;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_next;
  logic [TIME_W-1:0]  last_time_q;

  // Item in flight
  logic [DATA_W-1:0]  reading_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic [DATA_W:0]    diff_q;
  logic [DATA_W:0]    mag;
  logic               suppress;
  logic               store_q;
  logic [DELTA_W-1:0] delta_q;

  // Output register
  logic               out_valid_q;
  logic               stored_q;
  logic [DELTA_W-1:0] out_delta_q;
  logic [COUNT_W-1:0] out_count_q;

  logic               accept;
  logic               commit;
  logic               div_start;
  logic [DELTA_W-1:0] div_quotient;
  div_status_t        div_st;

  // ---------------------------------------------------------------------------
  // Configuration
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[PADDR_W-1 -: REG_IDX_W];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= '0;
      interval_q <= IVL_W'(1);
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_THRESHOLD: thr_q      <= pwdata[THR_W-1:0];
        REG_INTERVAL:  interval_q <= pwdata[IVL_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: prdata = PDATA_W'(thr_q);
      REG_INTERVAL:  prdata = PDATA_W'(interval_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // The difference is formed at 33 bits, so its magnitude never wraps.
  assign mag      = diff_q[DATA_W] ? (~diff_q + 1'b1) : diff_q;
  assign suppress = (mag < (DATA_W + 1)'(thr_q));
  assign div_start = (state_q == S_CMP) && !suppress;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = (count_q == '0) ? S_DONE : S_DIFF;
      S_DIFF: state_d = S_CMP;
      S_CMP:  state_d = suppress ? S_DONE : S_DIV;
      S_DIV:  if (div_st.done) state_d = S_DONE;
      S_DONE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      store_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        store_q <= 1'b1;
      end else if (state_q == S_CMP) begin
        store_q <= !suppress;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      reading_q <= reading_i;
      now_q     <= now_seconds_i;
      elapsed_q <= now_seconds_i - last_time_q;
      delta_q   <= '0;
    end
    if (state_q == S_DIFF) begin
      diff_q <= {rdata_q[DATA_W-1], rdata_q} - {reading_q[DATA_W-1], reading_q};
    end
    if ((state_q == S_DIV) && div_st.done) begin
      delta_q <= div_quotient;
    end
  end

  ddtl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .elapsed_i  (elapsed_q),
    .interval_i (interval_q),
    .quotient_o (div_quotient),
    .status_o   (div_st)
  );

  // ---------------------------------------------------------------------------
  // Ring buffer
  assign newest_addr = (slot_q == '0) ? ADDR_W'(DEPTH - 1) : slot_q - 1'b1;

  // The newest entry is read every cycle; its address only moves on a commit.
  always_ff @(posedge clk_i) begin
    rdata_q <= record_store_q[newest_addr][DATA_W-1:0];
    if (commit && store_q) begin
      record_store_q[slot_q] <= {delta_q, reading_q};
    end
  end

  assign count_next = (store_q && (count_q != COUNT_W'(DEPTH))) ? count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      count_q     <= '0;
      last_time_q <= '0;
    end else if (commit && store_q) begin
      slot_q      <= (slot_q == ADDR_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
      count_q     <= count_next;
      last_time_q <= now_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      stored_q    <= store_q;
      out_delta_q <= store_q ? delta_q : '0;
      out_count_q <= count_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stored_o         = stored_q;
  assign interval_delta_o = out_delta_q;
  assign entry_count_o    = out_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  `ASSERT_CLK(a_count_bound, count_q <= COUNT_W'(DEPTH), "entry count above depth")
  `ASSERT_CLK(a_idle_div_free, in_ready_o |-> !div_st.busy, "divider busy while idle")
  `ASSERT_ALWAYS(a_done_in_div, div_st.done |-> (state_q == S_DIV), "divider done outside wait")
  `ASSERT_CLK(a_drop_no_delta, (out_valid_o && !stored_o) |-> (interval_delta_o == '0),
              "dropped item carries a delta")
  `ASSERT_CLK(a_slot_follows, (commit && store_q) |=> (newest_addr == $past(slot_q)),
              "newest entry does not follow the write")

endmodule

`default_nettype wire
